### design/ilt_pkg.sv
// ----------------------------------------------------------------------------
// ilt_pkg: shared definitions for the INI line tokenizer
// Parser states, result event and error codes, character constants and the
// result record that moves from the classifier to the output stage.
// ----------------------------------------------------------------------------
package ilt_pkg;

  // Default width of the internal line counter and the width shown on the port.
  localparam int DEF_LINE_WIDTH = 16;
  localparam int OUT_LINE_W     = 16;

  // Byte values the parser reacts to.
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_RBR  = 8'h5D;
  localparam logic [7:0] CH_DEL  = 8'h7F;

  // Parser states; the last one latches a syntax error.
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_COMMENT = 3'd1,
    ST_SECTION = 3'd2,
    ST_KEY     = 3'd3,
    ST_KEYDONE = 3'd4,
    ST_EQUAL   = 3'd5,
    ST_VALUE   = 3'd6,
    ST_ERROR   = 3'd7
  } state_t;

  // Tag given to each byte.
  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_SEC_BEG = 4'd1,
    EV_SEC_CHR = 4'd2,
    EV_SEC_END = 4'd3,
    EV_KEY_1ST = 4'd4,
    EV_KEY_CHR = 4'd5,
    EV_VAL_1ST = 4'd6,
    EV_VAL_CHR = 4'd7,
    EV_PAIR    = 4'd8,
    EV_ERROR   = 4'd9
  } event_t;

  // Syntax error codes.
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_TAB_SECTION = 3'd1,
    ERR_NL_SECTION  = 3'd2,
    ERR_NL_KEY      = 3'd3,
    ERR_NO_EQUALS   = 3'd4,
    ERR_SPACE_KEY   = 3'd5,
    ERR_EMPTY_VALUE = 3'd6
  } err_t;

  // One classified byte.
  typedef struct packed {
    event_t                  event_res;
    logic [7:0]              char_out;
    err_t                    error_code;
    logic [OUT_LINE_W-1:0]   line_number;
  } result_t;

endpackage

### design/ilt_classify.sv
// ----------------------------------------------------------------------------
// ilt_classify: parser state and byte classification
// Holds the parser state and the line counter and tags one byte per
// transaction; state advances only when the result moves on.
// ----------------------------------------------------------------------------
module ilt_classify
  import ilt_pkg::*;
#(
  parameter int LINE_WIDTH = DEF_LINE_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] byte_in,
  input  logic       doc_start,
  output result_t    res
);

  state_t                state_r, state_nxt;
  logic [LINE_WIDTH-1:0] line_r, line_nxt;

  state_t                base_state;
  logic [LINE_WIDTH-1:0] base_line;
  logic                  ctrl_drop;
  logic                  line_inc;
  event_t                ev;
  logic [7:0]            ch;
  err_t                  err;

  // A document start returns to idle with a cleared counter before the byte.
  assign base_state = doc_start ? ST_IDLE : state_r;
  assign base_line  = doc_start ? '0 : line_r;

  // Control bytes other than tab and newline are dropped.
  assign ctrl_drop = ((byte_in < CH_SP) || (byte_in == CH_DEL)) &&
                     (byte_in != CH_TAB) && (byte_in != CH_NL);

  // Next state and byte tag.
  always_comb begin
    state_nxt = base_state;
    line_inc  = 1'b0;
    ev        = EV_NONE;
    ch        = 8'h00;
    err       = ERR_NONE;
    if (!ctrl_drop) begin
      unique case (base_state)
        ST_IDLE: begin
          if (byte_in == CH_SEMI) begin
            state_nxt = ST_COMMENT;
          end else if (byte_in == CH_LBR) begin
            line_inc  = 1'b1;
            state_nxt = ST_SECTION;
            ev        = EV_SEC_BEG;
          end else if (byte_in == CH_SP || byte_in == CH_TAB || byte_in == CH_NL) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_KEY;
            ev        = EV_KEY_1ST;
            ch        = byte_in;
          end
        end
        ST_COMMENT: begin
          if (byte_in == CH_NL) begin
            state_nxt = ST_IDLE;
            line_inc  = 1'b1;
          end
        end
        ST_SECTION: begin
          if (byte_in == CH_RBR) begin
            state_nxt = ST_IDLE;
            line_inc  = 1'b1;
            ev        = EV_SEC_END;
          end else if (byte_in == CH_TAB) begin
            ev  = EV_ERROR;
            err = ERR_TAB_SECTION;
          end else if (byte_in == CH_NL) begin
            ev  = EV_ERROR;
            err = ERR_NL_SECTION;
          end else begin
            ev = EV_SEC_CHR;
            ch = byte_in;
          end
        end
        ST_KEY: begin
          if (byte_in == CH_SP) begin
            state_nxt = ST_KEYDONE;
          end else if (byte_in == CH_EQ) begin
            state_nxt = ST_EQUAL;
          end else if (byte_in == CH_TAB) begin
            state_nxt = ST_KEY;
          end else if (byte_in == CH_NL) begin
            ev  = EV_ERROR;
            err = ERR_NL_KEY;
          end else begin
            ev = EV_KEY_CHR;
            ch = byte_in;
          end
        end
        ST_KEYDONE: begin
          if (byte_in == CH_SP || byte_in == CH_TAB) begin
            state_nxt = ST_KEYDONE;
          end else if (byte_in == CH_NL) begin
            ev  = EV_ERROR;
            err = ERR_NO_EQUALS;
          end else if (byte_in == CH_EQ) begin
            state_nxt = ST_EQUAL;
          end else begin
            ev  = EV_ERROR;
            err = ERR_SPACE_KEY;
          end
        end
        ST_EQUAL: begin
          if (byte_in == CH_SP || byte_in == CH_TAB) begin
            state_nxt = ST_EQUAL;
          end else if (byte_in == CH_NL) begin
            ev  = EV_ERROR;
            err = ERR_EMPTY_VALUE;
          end else begin
            state_nxt = ST_VALUE;
            ev        = EV_VAL_1ST;
            ch        = byte_in;
          end
        end
        ST_VALUE: begin
          if (byte_in == CH_NL) begin
            ev        = EV_PAIR;
            line_inc  = 1'b1;
            state_nxt = ST_IDLE;
          end else if (byte_in == CH_SEMI) begin
            ev        = EV_PAIR;
            state_nxt = ST_COMMENT;
          end else begin
            ev = EV_VAL_CHR;
            ch = byte_in;
          end
        end
        ST_ERROR: begin
          state_nxt = ST_ERROR;
        end
      endcase
      if (ev == EV_ERROR) begin
        state_nxt = ST_ERROR;
      end
    end
  end

  // Saturating line counter.
  assign line_nxt = (line_inc && (base_line != {LINE_WIDTH{1'b1}})) ?
                    base_line + {{(LINE_WIDTH-1){1'b0}}, 1'b1} : base_line;

  // Port view of the counter: zero-extended or clamped to the port width.
  logic [OUT_LINE_W-1:0] line_out;
  generate
    if (LINE_WIDTH > OUT_LINE_W) begin : g_clamp
      assign line_out = (|line_nxt[LINE_WIDTH-1:OUT_LINE_W]) ?
                        {OUT_LINE_W{1'b1}} : line_nxt[OUT_LINE_W-1:0];
    end else if (LINE_WIDTH == OUT_LINE_W) begin : g_same
      assign line_out = line_nxt;
    end else begin : g_extend
      assign line_out = {{(OUT_LINE_W-LINE_WIDTH){1'b0}}, line_nxt};
    end
  endgenerate

  assign res.event_res   = ev;
  assign res.char_out    = ch;
  assign res.error_code  = err;
  assign res.line_number = line_out;

  // Parser state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      line_r  <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
    end
  end

`ifndef SYNTHESIS
  // An error transaction latches the error state.
  a_err_latch: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (ev == EV_ERROR) |=> state_r == ST_ERROR)
    else $error("error event did not latch the error state");

  // Without a document start the line counter never goes down.
  a_line_mono: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !doc_start |=> line_r >= $past(line_r))
    else $error("line counter decreased");

  // A byte is shown only with a character event.
  a_char_tag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (ch != 8'h00) |-> (ev == EV_SEC_CHR) || (ev == EV_KEY_1ST) ||
      (ev == EV_KEY_CHR) || (ev == EV_VAL_1ST) || (ev == EV_VAL_CHR))
    else $error("character shown with a non-character event");

  // The error code is set exactly with an error event.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> ((err != ERR_NONE) == (ev == EV_ERROR)))
    else $error("error code and error event disagree");
`endif

endmodule

### design/ilt_out_stage.sv
// ----------------------------------------------------------------------------
// ilt_out_stage: result register
// Holds one classified byte until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module ilt_out_stage
  import ilt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  output logic        can_load,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [3:0]  out_tuser
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // The register may take a new result when it is empty or being drained.
  assign can_load = !valid_r || out_tready;

  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.event_res;
  assign out_tdata  = {5'b00000, res_r.line_number, res_r.error_code, res_r.char_out};

endmodule

### design/ini_line_tokenizer_core.sv
// ----------------------------------------------------------------------------
// ini_line_tokenizer_core: byte-serial INI text tokenizer
// Tags each byte of an INI text as section, key or value material.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one text byte per transaction on in_tdata, with
// in_tuser set on the first byte of a new document; that byte returns the
// parser to idle, clears a latched error and zeroes the line counter.
// The result channel gives exactly one transaction per input byte: the event
// tag on out_tuser, and the byte, error code and line number on out_tdata.
// Each accepted byte passes through the input register and then the result
// register, whose valid bit drives out_tvalid; while the result register is
// full and not drained, the byte waits in the input register. The block
// takes one byte per cycle while the receiver keeps up, set by the single
// parser state register that each byte reads and updates. When the receiver
// stalls, the result register holds and the input register still takes one
// more byte; after that in_tready drops until the receiver drains. Reset
// empties both registers, puts the parser in idle and zeroes the line counter.
// ----------------------------------------------------------------------------
module ini_line_tokenizer_core
  import ilt_pkg::*;
#(
  parameter int LINE_WIDTH = DEF_LINE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tuser,   // [0] doc_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] char_out, [10:8] error_code,
                                  // [26:11] line_number, [31:27] zero
  output logic [3:0]  out_tuser   // [3:0] event_res
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_doc_r;
  logic       can_load;
  logic       advance;
  logic       in_take;
  result_t    res;

  // Move the held byte into the result register when it has room.
  assign advance   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  assign in_valid_nxt = in_take || (in_valid_r && !advance);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_doc_r  <= in_tuser;
    end
  end

  ilt_classify #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .byte_in   (in_byte_r),
    .doc_start (in_doc_r),
    .res       (res)
  );

  ilt_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### tb/ilt_token_checker.sv
// ----------------------------------------------------------------------------
// ilt_token_checker: result predictor and comparator for the INI tokenizer
// Watches both stream channels. Every accepted input byte runs through a
// local copy of the parser, and the predicted token is queued. Every accepted
// result is compared field by field with the oldest queued token.
// ----------------------------------------------------------------------------
module ilt_token_checker
  import ilt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tuser,   // [0] doc_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [7:0] char_out, [10:8] error_code,
                                  // [26:11] line_number, [31:27] zero
  input  logic [3:0]  out_tuser,  // [3:0] event_res
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          error_count,
  output int          line_peak
);

  // Local copy of the parser state and the tokens still owed by the block.
  state_t                    parse_q;
  logic [DEF_LINE_WIDTH-1:0] line_q;
  result_t                   pending_tokens[$];

  // The line counter sticks at all ones.
  function automatic logic [DEF_LINE_WIDTH-1:0] line_step(
    input logic [DEF_LINE_WIDTH-1:0] v
  );
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Classify one byte, advancing the local parser state.
  function automatic result_t classify_byte(input logic [7:0] c, input logic doc);
    result_t    r;
    event_t     ev;
    err_t       ec;
    logic [7:0] ch;
    ev = EV_NONE;
    ec = ERR_NONE;
    ch = '0;
    if (doc) begin
      parse_q = ST_IDLE;
      line_q  = '0;
    end
    // Control bytes other than tab and newline leave everything untouched.
    if (!((c < CH_SP || c == CH_DEL) && c != CH_TAB && c != CH_NL)) begin
      case (parse_q)
        ST_IDLE: begin
          if (c == CH_SEMI) begin
            parse_q = ST_COMMENT;
          end else if (c == CH_LBR) begin
            line_q  = line_step(line_q);
            parse_q = ST_SECTION;
            ev      = EV_SEC_BEG;
          end else if (!(c == CH_SP || c == CH_TAB || c == CH_NL)) begin
            parse_q = ST_KEY;
            ev      = EV_KEY_1ST;
            ch      = c;
          end
        end
        ST_COMMENT: begin
          if (c == CH_NL) begin
            parse_q = ST_IDLE;
            line_q  = line_step(line_q);
          end
        end
        ST_SECTION: begin
          if (c == CH_RBR) begin
            parse_q = ST_IDLE;
            line_q  = line_step(line_q);
            ev      = EV_SEC_END;
          end else if (c == CH_TAB) begin
            ev = EV_ERROR;
            ec = ERR_TAB_SECTION;
          end else if (c == CH_NL) begin
            ev = EV_ERROR;
            ec = ERR_NL_SECTION;
          end else begin
            ev = EV_SEC_CHR;
            ch = c;
          end
        end
        ST_KEY: begin
          if (c == CH_SP) begin
            parse_q = ST_KEYDONE;
          end else if (c == CH_EQ) begin
            parse_q = ST_EQUAL;
          end else if (c == CH_NL) begin
            ev = EV_ERROR;
            ec = ERR_NL_KEY;
          end else if (c != CH_TAB) begin
            ev = EV_KEY_CHR;
            ch = c;
          end
        end
        ST_KEYDONE: begin
          if (c == CH_NL) begin
            ev = EV_ERROR;
            ec = ERR_NO_EQUALS;
          end else if (c == CH_EQ) begin
            parse_q = ST_EQUAL;
          end else if (!(c == CH_SP || c == CH_TAB)) begin
            ev = EV_ERROR;
            ec = ERR_SPACE_KEY;
          end
        end
        ST_EQUAL: begin
          if (c == CH_NL) begin
            ev = EV_ERROR;
            ec = ERR_EMPTY_VALUE;
          end else if (!(c == CH_SP || c == CH_TAB)) begin
            parse_q = ST_VALUE;
            ev      = EV_VAL_1ST;
            ch      = c;
          end
        end
        ST_VALUE: begin
          if (c == CH_NL) begin
            ev      = EV_PAIR;
            line_q  = line_step(line_q);
            parse_q = ST_IDLE;
          end else if (c == CH_SEMI) begin
            ev      = EV_PAIR;
            parse_q = ST_COMMENT;
          end else begin
            ev = EV_VAL_CHR;
            ch = c;
          end
        end
        default: begin
          // A latched error swallows everything until the next document.
        end
      endcase
      if (ev == EV_ERROR) parse_q = ST_ERROR;
    end
    r.event_res   = ev;
    r.char_out    = ch;
    r.error_code  = ec;
    r.line_number = line_q;
    return r;
  endfunction

  // Compare finished transactions first, then predict the new byte.
  always @(posedge clk) begin : track
    result_t               want;
    logic [OUT_LINE_W-1:0] got_line;
    if (!rst_n) begin
      parse_q = ST_IDLE;
      line_q  = '0;
      pending_tokens.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        result_count++;
        got_line = out_tdata[26:11];
        if (int'(got_line) > line_peak) line_peak = int'(got_line);
        if (pending_tokens.size() == 0) begin
          $error("result with nothing expected: tuser %0d tdata 0x%08h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = pending_tokens.pop_front();
          if (out_tuser !== want.event_res) begin
            $error("event_res mismatch: expected %0d, actual %0d", want.event_res, out_tuser);
            fail_count++;
          end
          if (out_tdata[7:0] !== want.char_out) begin
            $error("char_out mismatch: expected 0x%02h, actual 0x%02h",
                   want.char_out, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[10:8] !== want.error_code) begin
            $error("error_code mismatch: expected %0d, actual %0d",
                   want.error_code, out_tdata[10:8]);
            fail_count++;
          end
          if (got_line !== want.line_number) begin
            $error("line_number mismatch: expected %0d, actual %0d",
                   want.line_number, got_line);
            fail_count++;
          end
          if (out_tdata[31:27] !== 5'b0) begin
            $error("tdata padding mismatch: expected 0, actual 0x%02h", out_tdata[31:27]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = classify_byte(in_tdata, in_tuser);
        if (want.event_res == EV_ERROR) error_count++;
        pending_tokens.push_back(want);
      end
    end
    pending_count = pending_tokens.size();
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the INI line tokenizer
// Feeds a short directed text, then randomly built INI documents with broken
// lines and noise mixed in, then a run of empty sections back to back. Both
// channels idle at random; a separate checker predicts and compares every
// result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
  import ilt_pkg::*;
();

  localparam int RANDOM_ITEMS  = 1050;
  localparam int SECTION_PAIRS = 64;
  localparam int CYCLE_LIMIT   = 4000000;

  // Character classes for generated text.
  localparam int TXT_SECTION    = 0;
  localparam int TXT_KEY_HEAD   = 1;
  localparam int TXT_KEY        = 2;
  localparam int TXT_VALUE_HEAD = 3;
  localparam int TXT_VALUE      = 4;
  localparam int TXT_COMMENT    = 5;

  // Directed text, first byte in the top bits. It walks through a comment,
  // a section with a high byte, two pairs with dropped control bytes, a
  // latched tab error and a new document that clears it.
  localparam int DIRECTED_LEN = 25;
  localparam logic [DIRECTED_LEN*8-1:0] DIRECTED_TEXT = {
    CH_SEMI, 8'h01, CH_NL, CH_LBR, 8'hFF, CH_RBR, CH_NL, "k", 8'h00, CH_EQ,
    CH_SP, 8'h80, CH_DEL, "v", CH_SEMI, CH_NL, "a", CH_SP, CH_EQ, "x",
    CH_NL, CH_LBR, CH_TAB, "z", "A"
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;

  int   fail_count;
  int   pending_count;
  int   result_count;
  int   error_count;
  int   line_peak;
  int   live_cnt   = 0;
  int   doc_cnt    = 0;
  int   burst_left = 0;
  int   cycle_cnt  = 0;
  int   rx_mode    = 0;
  int   rx_left    = 0;
  logic next_doc   = 1'b1;

  always #4 clk = ~clk;

  ini_line_tokenizer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ilt_token_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .error_count   (error_count),
    .line_peak     (line_peak)
  );

  // Receiver: switches between always ready, mostly ready, mostly stalled
  // and a periodic stall pattern.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rx_left % 8) < 5);
    endcase
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_count);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CH_SP : CH_TAB;
  endfunction

  // Send one byte as a transaction. The sender runs in bursts with random
  // gaps; the document start flag rides on the first byte after a request.
  task automatic put(input logic [7:0] b, input bit live);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= next_doc;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    burst_left--;
    if (next_doc) doc_cnt++;
    next_doc = 1'b0;
    if (live) live_cnt++;
  endtask

  // Send n characters of one class, with dropped control bytes sprinkled in.
  task automatic put_text(input int cls, input int n);
    logic [7:0] c;
    logic       bad;
    repeat (n) begin
      if ($urandom_range(0, 29) == 0) begin
        do c = 8'($urandom_range(0, 31)); while (c == CH_TAB || c == CH_NL);
        if ($urandom_range(0, 7) == 0) c = CH_DEL;
        put(c, 1'b0);
      end
      do begin
        if (cls == TXT_COMMENT) c = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(128, 255));
        else c = 8'($urandom_range(32, 126));
        case (cls)
          TXT_SECTION:    bad = (c == CH_RBR);
          TXT_KEY_HEAD:   bad = (c == CH_SP || c == CH_SEMI || c == CH_LBR);
          TXT_KEY:        bad = (c == CH_SP || c == CH_EQ);
          TXT_VALUE_HEAD: bad = (c == CH_SP);
          TXT_VALUE:      bad = (c == CH_SEMI);
          default:        bad = (c == CH_NL);
        endcase
      end while (bad);
      put(c, 1'b1);
    end
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  initial begin
    err_t kind;
    int   roll;
    int   next_pause;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text; the last byte opens a new document.
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (i == DIRECTED_LEN - 1) next_doc = 1'b1;
      put(DIRECTED_TEXT[(DIRECTED_LEN-1-i)*8 +: 8], 1'b0);
    end
    drain_wait();

    // Random documents, mostly well formed lines.
    next_doc   = 1'b1;
    next_pause = 300;
    while (live_cnt < RANDOM_ITEMS) begin
      if (live_cnt >= next_pause) begin
        drain_wait();
        next_pause += $urandom_range(200, 400);
      end
      if ($urandom_range(0, 24) == 0) next_doc = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        // Broken line: ends in an error, then filler that the latch swallows.
        kind = err_t'($urandom_range(ERR_TAB_SECTION, ERR_EMPTY_VALUE));
        case (kind)
          ERR_TAB_SECTION: begin
            put(CH_LBR, 1'b1);
            put_text(TXT_SECTION, $urandom_range(0, 3));
            put(CH_TAB, 1'b1);
          end
          ERR_NL_SECTION: begin
            put(CH_LBR, 1'b1);
            put_text(TXT_SECTION, $urandom_range(0, 3));
            put(CH_NL, 1'b1);
          end
          ERR_NL_KEY: begin
            put_text(TXT_KEY_HEAD, 1);
            put_text(TXT_KEY, $urandom_range(0, 3));
            put(CH_NL, 1'b1);
          end
          ERR_NO_EQUALS: begin
            put_text(TXT_KEY_HEAD, 1);
            put_text(TXT_KEY, $urandom_range(0, 3));
            put(CH_SP, 1'b1);
            repeat ($urandom_range(0, 1)) put(blank_char(), 1'b1);
            put(CH_NL, 1'b1);
          end
          ERR_SPACE_KEY: begin
            put_text(TXT_KEY_HEAD, 1);
            put(CH_SP, 1'b1);
            put_text(TXT_KEY, 1);
          end
          default: begin
            put_text(TXT_KEY_HEAD, 1);
            put(CH_EQ, 1'b1);
            repeat ($urandom_range(0, 2)) put(blank_char(), 1'b1);
            put(CH_NL, 1'b1);
          end
        endcase
        repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 255)), 1'b0);
        next_doc = 1'b1;
      end else if (roll < 17) begin
        // Raw noise of any byte value.
        repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)), 1'b1);
        next_doc = 1'b1;
      end else if (roll < 32) begin
        // Section header.
        put(CH_LBR, 1'b1);
        put_text(TXT_SECTION, $urandom_range(0, 6));
        put(CH_RBR, 1'b1);
        repeat ($urandom_range(0, 1)) put(CH_SP, 1'b1);
        put(CH_NL, 1'b1);
      end else if (roll < 44) begin
        // Comment line.
        put(CH_SEMI, 1'b1);
        put_text(TXT_COMMENT, $urandom_range(0, 8));
        put(CH_NL, 1'b1);
      end else if (roll < 50) begin
        // Blank line.
        repeat ($urandom_range(0, 2)) put(blank_char(), 1'b1);
        put(CH_NL, 1'b1);
      end else begin
        // Key and value pair, sometimes with a trailing comment.
        put_text(TXT_KEY_HEAD, 1);
        put_text(TXT_KEY, $urandom_range(0, 5));
        if ($urandom_range(0, 5) == 0) put(CH_TAB, 1'b1);
        repeat ($urandom_range(0, 2)) put(blank_char(), 1'b1);
        put(CH_EQ, 1'b1);
        repeat ($urandom_range(0, 2)) put(blank_char(), 1'b1);
        put_text(TXT_VALUE_HEAD, 1);
        put_text(TXT_VALUE, $urandom_range(0, 6));
        if ($urandom_range(0, 4) == 0) begin
          put(CH_SEMI, 1'b1);
          put_text(TXT_COMMENT, $urandom_range(0, 4));
        end
        put(CH_NL, 1'b1);
      end
    end
    drain_wait();

    // Empty sections back to back: each one bumps the line counter twice.
    next_doc = 1'b1;
    repeat (SECTION_PAIRS) begin
      put(CH_LBR, 1'b0);
      put(CH_RBR, 1'b0);
    end
    put(CH_NL, 1'b0);

    drain_wait();
    repeat (8) @(posedge clk);

    $display("summary: %0d results checked over %0d documents, %0d syntax errors predicted",
             result_count, doc_cnt, error_count);
    $display("summary: %0d random text bytes, line counter peaked at %0d",
             live_cnt, line_peak);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
